>>> hw/rtl/bdqs_pkg.sv
// ----------------------------------------------------------------------------
// Bounded deque package
// Shared widths, command codes, status codes and controller states.
// ----------------------------------------------------------------------------
package bdqs_pkg;

   localparam int DEFAULT_DEPTH = 16;

   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd5;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 2'd0,
      STS_EMPTY     = 2'd1,
      STS_FULL      = 2'd2,
      STS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_SCAN,
      ST_SHIFT
   } state_type;

endpackage

>>> hw/rtl/bounded_deque_with_search.sv
// ----------------------------------------------------------------------------
// Bounded deque with search
// Ring-buffer deque of signed words in one synchronous memory, with push and
// pop at both ends, search, and delete of the first matching word.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low, and exactly one
// result word follows, marked by rsp_valid for one cycle; the receiver
// cannot stall it. Pushes, unknown command codes, and any command refused
// for an empty or full list give their result in the next cycle without
// raising busy, so a new command can follow at once. A pop reads the
// memory into a register and gives its result from ST_POP. A search
// reads the list from the front in ST_SCAN until it matches or passes the
// last entry. A delete then moves each entry behind the match one place
// forward in ST_SHIFT, one word at a time, since each passes through the
// single read port and the single write port of the entry memory.
module bounded_deque_with_search #(
   parameter int DEPTH = bdqs_pkg::DEFAULT_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic        [bdqs_pkg::CMD_W-1:0]    req_command,
   input  logic signed [bdqs_pkg::VALUE_W-1:0]  req_operand_value,
   output logic                                rsp_valid,
   output logic        [bdqs_pkg::STATUS_W-1:0] rsp_status,
   output logic                                rsp_found,
   output logic signed [bdqs_pkg::VALUE_W-1:0]  rsp_popped_value,
   output logic        [bdqs_pkg::COUNT_W-1:0]  rsp_entry_count
);
   import bdqs_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int OCCW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0]   LAST_POS   = AW'(DEPTH - 1);
   localparam logic [AW:0]     RING_SIZE  = (AW + 1)'(DEPTH);
   localparam logic [OCCW-1:0] FULL_COUNT = OCCW'(DEPTH);

   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= RING_SIZE) begin
         sum = sum - RING_SIZE;
      end
      return sum[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
      return (p == LAST_POS) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
      return (p == '0) ? LAST_POS : p - 1'b1;
   endfunction

   logic signed [VALUE_W-1:0] mem [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic        [AW-1:0]      rd_addr;
   logic                      wr_en;
   logic        [AW-1:0]      wr_addr;
   logic signed [VALUE_W-1:0] wr_data;

   state_type                 state_ff, state_in;
   logic        [OCCW-1:0]    occ_ff, occ_in;
   logic        [AW-1:0]      front_ff, front_in;
   logic        [CMD_W-1:0]   cmd_ff, cmd_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic        [AW-1:0]      ptr_ff, ptr_in;
   logic        [AW-1:0]      k_ff, k_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic signed [VALUE_W-1:0] rsp_popped_ff, rsp_popped_in;
   logic        [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [OCCW-1:0]         occ_m1;
   logic [OCCW-1:0]         k_next;
   logic [OCCW+COUNT_W-1:0] occ_ext;
   logic                    is_full;
   logic                    is_empty;

   assign occ_m1   = occ_ff - 1'b1;
   assign k_next   = OCCW'(k_ff) + 1'b1;
   assign occ_ext  = {{COUNT_W{1'b0}}, occ_in};
   assign is_full  = (occ_ff >= FULL_COUNT);
   assign is_empty = (occ_ff == '0);

   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      front_in      = front_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      ptr_in        = ptr_ff;
      k_in          = k_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_popped_in = rsp_popped_ff;
      rd_addr       = front_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = rd_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in        = req_command;
               val_in        = req_operand_value;
               rsp_status_in = STS_OK;
               rsp_found_in  = 1'b0;
               rsp_popped_in = '0;
               case (req_command)
                  CMD_PUSH_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = ring_add(front_ff, occ_ff[AW-1:0]);
                        wr_data = req_operand_value;
                        occ_in  = occ_ff + 1'b1;
                     end
                  end
                  CMD_PUSH_FRONT: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        front_in = ring_dec(front_ff);
                        wr_en    = 1'b1;
                        wr_addr  = ring_dec(front_ff);
                        wr_data  = req_operand_value;
                        occ_in   = occ_ff + 1'b1;
                     end
                  end
                  CMD_POP_BACK: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        rd_addr  = ring_add(front_ff, occ_m1[AW-1:0]);
                        occ_in   = occ_m1;
                        state_in = ST_POP;
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        rd_addr  = front_ff;
                        front_in = ring_inc(front_ff);
                        occ_in   = occ_m1;
                        state_in = ST_POP;
                     end
                  end
                  CMD_SEARCH, CMD_DELETE: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        rd_addr  = front_ff;
                        ptr_in   = front_ff;
                        k_in     = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            rsp_valid_in  = 1'b1;
            rsp_popped_in = rd_data_ff;
            state_in      = ST_IDLE;
         end
         ST_SCAN: begin
            rd_addr = ring_inc(ptr_ff);
            if (rd_data_ff == val_ff) begin
               rsp_found_in = 1'b1;
               if (cmd_ff == CMD_DELETE) begin
                  state_in = ST_SHIFT;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (k_next == occ_ff) begin
               rsp_status_in = STS_NOT_FOUND;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               ptr_in = ring_inc(ptr_ff);
               k_in   = k_ff + 1'b1;
            end
         end
         ST_SHIFT: begin
            if (k_next == occ_ff) begin
               occ_in       = occ_m1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               wr_en   = 1'b1;
               wr_addr = ptr_ff;
               wr_data = rd_data_ff;
               rd_addr = ring_inc(ring_inc(ptr_ff));
               ptr_in  = ring_inc(ptr_ff);
               k_in    = k_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_count_in = occ_ext[COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         front_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         front_ff     <= front_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      ptr_ff        <= ptr_in;
      k_ff          <= k_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_entry_count  = rsp_count_ff;

`ifndef SYNTH
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL_COUNT)
      else $error("occupancy above depth");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result word while a command is still running");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_status_ff == STS_OK))
      else $error("found flag with a failing status");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (OCCW'(k_ff) < occ_ff))
      else $error("shift offset beyond the list");

   a_occ_change: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_SHIFT) |=> $stable(occ_ff))
      else $error("count changed outside accept or delete");
`endif

endmodule
